@@ hw/rtl/sawa_pkg.sv @@
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender package
// Shared types, codes and constants of the ARQ sender front, queue and back.
// ----------------------------------------------------------------------------
package sawa_pkg;

  // Default and largest supported frame payload, in bytes.
  localparam int unsigned MAX_PAYLOAD      = 60;
  localparam int unsigned MAX_PAYLOAD_HIGH = 62;

  // Length and replay position width: a position runs up to length + 1.
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_HIGH + 2);

  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // Depth of the command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_CSUM   = 3'd1,
    KIND_SEQ    = 3'd2,
    KIND_ACKED  = 3'd3,
    KIND_REJECT = 3'd4
  } kind_e;

  // Work handed from front to back.
  typedef enum logic [1:0] {
    CMD_SINGLE    = 2'd0,  // one result word
    CMD_FRAME_END = 2'd1,  // last byte, checksum, sequence number
    CMD_REPLAY    = 2'd2   // stored frame, checksum, sequence number
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] ack_seq;
  } sawa_in_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_retry;
    logic       out_last;
  } sawa_out_t;

  typedef struct packed {
    cmd_e             cmd;
    kind_e            kind;
    logic [7:0]       data;
    logic [7:0]       csum;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
  } sawa_cmd_t;

  typedef struct packed {
    logic full;
    logic has_replay;
  } sawa_qstat_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } sawa_wr_t;

endpackage

@@ hw/rtl/sawa_front.sv @@
// ----------------------------------------------------------------------------
// ARQ sender front
// Accepts input words, keeps the protocol state and pushes commands.
// ----------------------------------------------------------------------------
module sawa_front import sawa_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sawa_in_t    in_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  sawa_qstat_t qstat_i,
  output logic        push_o,
  output sawa_cmd_t   cmd_o,
  output sawa_wr_t    wr_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       csum_q, csum_d;
  logic [7:0]       seq_q, seq_d;
  logic             wait_q, wait_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [15:0]      timeout_q;
  logic [7:0]       csum_next;
  logic [15:0]      tick_cnt;
  logic             accept;

  // The store must not change under a replay, so input waits for it to drain.
  assign in_ready_o  = !qstat_i.full && !qstat_i.has_replay;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign csum_next   = csum_q ^ in_data_i.data_byte;
  assign tick_cnt    = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    len_d     = len_q;
    csum_d    = csum_q;
    seq_d     = seq_q;
    wait_d    = wait_q;
    elapsed_d = elapsed_q;
    push_o    = 1'b0;
    cmd_o     = '{cmd: CMD_SINGLE, kind: KIND_BYTE, data: in_data_i.data_byte,
                  csum: csum_q, seq: seq_q, len: len_q};
    wr_o      = '{en: 1'b0, addr: len_q, data: in_data_i.data_byte};
    if (accept) begin
      unique case (in_data_i.operation)
        OP_BYTE: begin
          push_o = 1'b1;
          if (wait_q || (len_q >= LEN_W'(MaxPayload))) begin
            cmd_o.kind = KIND_REJECT;
            cmd_o.data = 8'd0;
          end else begin
            wr_o.en = 1'b1;
            len_d   = len_q + 1'b1;
            csum_d  = csum_next;
            if (in_data_i.last_byte) begin
              cmd_o.cmd  = CMD_FRAME_END;
              cmd_o.csum = csum_next;
              wait_d     = 1'b1;
              elapsed_d  = 16'd0;
            end
          end
        end
        OP_ACK: begin
          if (wait_q) begin
            push_o    = 1'b1;
            elapsed_d = 16'd0;
            if (in_data_i.ack_seq == seq_q) begin
              cmd_o.cmd = CMD_REPLAY;
            end else begin
              cmd_o.kind = KIND_ACKED;
              cmd_o.data = seq_q;
              seq_d      = seq_q + 8'd1;
              len_d      = '0;
              csum_d     = 8'd0;
              wait_d     = 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (wait_q) begin
            // A timeout of zero fires on the first tick, like a timeout of one.
            if (tick_cnt >= timeout_q) begin
              push_o    = 1'b1;
              cmd_o.cmd = CMD_REPLAY;
              elapsed_d = 16'd0;
            end else begin
              elapsed_d = tick_cnt;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      csum_q    <= 8'd0;
      seq_q     <= 8'd0;
      wait_q    <= 1'b0;
      elapsed_q <= 16'd0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      len_q     <= len_d;
      csum_q    <= csum_d;
      seq_q     <= seq_d;
      wait_q    <= wait_d;
      elapsed_q <= elapsed_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hw/rtl/sawa_cmdq.sv @@
// ----------------------------------------------------------------------------
// ARQ sender command queue
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module sawa_cmdq import sawa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sawa_cmd_t   cmd_i,
  input  logic        pop_i,
  output sawa_cmd_t   head_o,
  output logic        empty_o,
  output sawa_qstat_t qstat_o
);

  localparam int unsigned PtrW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  sawa_cmd_t             ent_q [CMDQ_DEPTH];
  logic [CMDQ_DEPTH-1:0] vld_q, vld_d;
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                  has_replay;

  assign head_o  = ent_q[rd_ptr_q];
  assign empty_o = !vld_q[rd_ptr_q];

  always_comb begin
    has_replay = 1'b0;
    for (int i = 0; i < CMDQ_DEPTH; i++) begin
      if (vld_q[i] && (ent_q[i].cmd == CMD_REPLAY)) begin
        has_replay = 1'b1;
      end
    end
  end

  assign qstat_o = '{full: vld_q[wr_ptr_q], has_replay: has_replay};

  always_comb begin
    vld_d    = vld_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (pop_i) begin
      vld_d[rd_ptr_q] = 1'b0;
      rd_ptr_d = (rd_ptr_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i) begin
      vld_d[wr_ptr_q] = 1'b1;
      wr_ptr_d = (wr_ptr_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      vld_q    <= vld_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/sawa_back.sv @@
// ----------------------------------------------------------------------------
// ARQ sender back
// Holds the frame store and turns commands into result words.
// ----------------------------------------------------------------------------
module sawa_back import sawa_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sawa_wr_t  wr_i,
  input  sawa_cmd_t head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sawa_out_t out_data_o
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  logic [7:0]       mem_q [MaxPayload];
  logic [7:0]       rdata_q;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] nbytes;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_c;
  logic [7:0]       byte_q, byte_c;
  logic             retry_q, last_q, last_c;
  logic             mem_sel_q, mem_c;
  logic             advance, emit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
  end

  assign advance = !out_valid_q || out_ready_i;
  assign emit    = advance && !empty_i;
  assign nbytes  = (head_i.cmd == CMD_REPLAY) ? head_i.len : LEN_W'(1);

  // Word at the current position of the head command.
  always_comb begin
    kind_c = head_i.kind;
    byte_c = head_i.data;
    last_c = 1'b1;
    mem_c  = 1'b0;
    if (head_i.cmd != CMD_SINGLE) begin
      if (pos_q < nbytes) begin
        kind_c = KIND_BYTE;
        last_c = 1'b0;
        mem_c  = (head_i.cmd == CMD_REPLAY);
      end else if (pos_q == nbytes) begin
        kind_c = KIND_CSUM;
        byte_c = head_i.csum;
        last_c = 1'b0;
      end else begin
        kind_c = KIND_SEQ;
        byte_c = head_i.seq;
      end
    end
  end

  assign pop_o       = emit && last_c;
  assign out_valid_d = advance ? !empty_i : out_valid_q;
  assign pos_d       = emit ? (last_c ? '0 : pos_q + 1'b1) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= kind_c;
      byte_q    <= byte_c;
      retry_q   <= (head_i.cmd == CMD_REPLAY);
      last_q    <= last_c;
      mem_sel_q <= mem_c;
      if (mem_c) begin
        rdata_q <= mem_q[pos_q[AddrW-1:0]];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{out_kind: kind_q, out_byte: mem_sel_q ? rdata_q : byte_q,
                         out_retry: retry_q, out_last: last_q};

endmodule

@@ hw/rtl/stop_and_wait_arq_sender.sv @@
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender
// Frames payload bytes, adds checksum and sequence number, and retransmits
// the stored frame on timeout or on a repeated acknowledgement.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per item: a payload byte, an
// acknowledgement or a time tick. The output channel gives result words;
// the last word caused by an input word carries out_last.
// The configuration channel writes the timeout in ticks; it is always ready
// and must only be written while the block is idle.
// Commands are queued and result words registered. A plain payload byte
// gives one result word, and the block takes one input word per cycle
// while the command queue has room. While the receiver is ready, a last
// byte gives three words and a retransmission frame length plus two, one
// per cycle, with stored bytes read from the frame store's registered port;
// input is held off until the replay has left the command queue.
// Reset clears the protocol state, sets the timeout to 200 ticks and leaves
// the frame store undefined; no clearing pass is needed because only bytes
// written in the current frame are ever read back.
// When the receiver stalls, the output word holds, the queue fills and the
// input side stops taking words.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender import sawa_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sawa_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sawa_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // Front to queue: one command per accepted word that causes results.
  logic        push;
  sawa_cmd_t   push_cmd;
  sawa_qstat_t qstat;
  // Queue to back: the head command, popped after its last word.
  sawa_cmd_t   head;
  logic        empty;
  logic        pop;
  // Front to frame store: byte writes while a frame is being built.
  sawa_wr_t    store_wr;

  sawa_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .wr_o       (store_wr)
  );

  sawa_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .qstat_o(qstat)
  );

  // The back side owns the frame store and the output register.
  sawa_back #(
    .MaxPayload(MaxPayload)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (store_wr),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ hw/rtl/sawa_checker.sv @@
// ----------------------------------------------------------------------------
// ARQ sender checker
// Port-level properties of the ARQ sender output stream.
// ----------------------------------------------------------------------------
module sawa_checker import sawa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input sawa_out_t out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // An accepted checksum is followed by the sequence number in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_data_o.out_kind == KIND_CSUM)
    |=> out_valid_o && (out_data_o.out_kind == KIND_SEQ))
    else $error("checksum not followed by sequence number");

  // A checksum never ends the words of an input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_kind == KIND_CSUM) |-> !out_data_o.out_last)
    else $error("checksum marked last");

  // Rejects and acknowledgements stand alone and are never retransmitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.out_kind == KIND_REJECT) ||
                    (out_data_o.out_kind == KIND_ACKED))
    |-> out_data_o.out_last && !out_data_o.out_retry)
    else $error("malformed reject or acknowledge word");

endmodule

bind stop_and_wait_arq_sender sawa_checker u_sawa_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender testbench
// Drives payload bytes, acknowledgements and ticks into the sender, predicts
// every result word with a cycle-free shadow of the protocol, and checks the
// output stream word by word under several timeouts and handshake patterns.
// ----------------------------------------------------------------------------

import sawa_pkg::*;

// Shadow of the sender protocol. Every accepted input word is run through the
// same frame, checksum, sequence and timeout rules as the block, and the result
// words it must cause are queued in arrival order for comparison.
class arq_sender_shadow;

  localparam int unsigned MAX_REPORTS = 10;

  logic [7:0]  frame_bytes [MAX_PAYLOAD];
  int unsigned frame_len;
  logic [7:0]  xor_sum;
  logic [7:0]  seq_no;
  bit          awaiting_ack;
  int unsigned ticks;
  logic [15:0] timeout;
  sawa_out_t   expected_words [$];
  int unsigned errors;

  function new(logic [15:0] reset_timeout);
    frame_len    = 0;
    xor_sum      = 8'h00;
    seq_no       = 8'h00;
    awaiting_ack = 1'b0;
    ticks        = 0;
    timeout      = reset_timeout;
    errors       = 0;
  endfunction

  function void emit(kind_e k, logic [7:0] b, logic retry);
    sawa_out_t r;
    r.out_kind  = k;
    r.out_byte  = b;
    r.out_retry = retry;
    r.out_last  = 1'b0;
    expected_words.push_back(r);
  endfunction

  // Retransmission: stored bytes, then checksum and sequence number.
  function void replay_frame();
    for (int unsigned i = 0; i < frame_len; i++) emit(KIND_BYTE, frame_bytes[i], 1'b1);
    emit(KIND_CSUM, xor_sum, 1'b1);
    emit(KIND_SEQ, seq_no, 1'b1);
    ticks = 0;
  endfunction

  function void take_word(sawa_in_t w);
    int unsigned queued_before;
    sawa_out_t   tail;
    queued_before = expected_words.size();
    case (op_e'(w.operation))
      OP_BYTE: begin
        if (awaiting_ack || frame_len >= MAX_PAYLOAD) begin
          emit(KIND_REJECT, 8'h00, 1'b0);
        end else begin
          frame_bytes[frame_len] = w.data_byte;
          frame_len++;
          xor_sum ^= w.data_byte;
          emit(KIND_BYTE, w.data_byte, 1'b0);
          if (w.last_byte) begin
            emit(KIND_CSUM, xor_sum, 1'b0);
            emit(KIND_SEQ, seq_no, 1'b0);
            awaiting_ack = 1'b1;
            ticks        = 0;
          end
        end
      end
      OP_ACK: begin
        if (awaiting_ack) begin
          if (w.ack_seq == seq_no) begin
            replay_frame();
          end else begin
            emit(KIND_ACKED, seq_no, 1'b0);
            seq_no++;
            frame_len    = 0;
            xor_sum      = 8'h00;
            awaiting_ack = 1'b0;
            ticks        = 0;
          end
        end
      end
      OP_TICK: begin
        if (awaiting_ack) begin
          if (ticks < 65535) ticks++;
          if (ticks >= ((timeout == 16'd0) ? 1 : timeout)) replay_frame();
        end
      end
      default: ;
    endcase
    // The final word caused by this input carries the last flag.
    if (expected_words.size() > queued_before) begin
      tail = expected_words.pop_back();
      tail.out_last = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  function void check_word(sawa_out_t got);
    sawa_out_t want;
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result word: kind %0d byte %02h retry %0b last %0b",
                 got.out_kind, got.out_byte, got.out_retry, got.out_last);
      return;
    end
    want = expected_words.pop_front();
    if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
        got.out_retry !== want.out_retry || got.out_last !== want.out_last) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("result word differs: expected kind %0d byte %02h retry %0b last %0b,",
                 want.out_kind, want.out_byte, want.out_retry, want.out_last);
        $display("  got kind %0d byte %02h retry %0b last %0b",
                 got.out_kind, got.out_byte, got.out_retry, got.out_last);
      end
    end
  endfunction
endclass

module tb_top;
  import sawa_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 11;
  // Results pass through the command queue and output register; this covers
  // words that cause no result but may still be moving through the front end.
  localparam int          SETTLE_CYCLES = 16;
  localparam int          LONG_HOLD     = 600;
  localparam int          WATCHDOG_NS   = 4_000_000;
  localparam logic [15:0] RESET_TIMEOUT = 16'd200;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  sawa_in_t    in_data    = '0;
  logic        out_ready  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = 16'd0;
  logic        in_ready;
  logic        out_valid;
  sawa_out_t   out_data;
  logic        cfg_ready;

  stop_and_wait_arq_sender dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  arq_sender_shadow sb;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_requests; the
  // receiver process counts the stretch down on its own.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  // Words waiting to be offered, and the protocol state that planning tracks
  // so that acknowledgements can be aimed at the right sequence number.
  sawa_in_t    word_plan [$];
  logic [7:0]  plan_seq     = 8'h00;
  bit          plan_waiting = 1'b0;
  int unsigned plan_len     = 0;
  int unsigned plan_timeout = RESET_TIMEOUT;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: every handshake is seen at the clock edge where it completes.
  // Inputs are noted before results are checked, though a result never
  // arrives in the same cycle as the word that causes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.take_word(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // Don't-care fields are randomized so that every input bit toggles.
  function automatic sawa_in_t word_of(op_e op, logic [7:0] d, logic l, logic [7:0] a);
    sawa_in_t w;
    w.operation = op;
    w.data_byte = d;
    w.last_byte = l;
    w.ack_seq   = a;
    return w;
  endfunction

  function automatic void plan_byte(logic [7:0] d, logic l);
    word_plan.push_back(word_of(OP_BYTE, d, l, 8'($urandom)));
    if (!plan_waiting && plan_len < MAX_PAYLOAD) begin
      plan_len++;
      if (l) plan_waiting = 1'b1;
    end
  endfunction

  function automatic void plan_ack(logic [7:0] a);
    word_plan.push_back(word_of(OP_ACK, 8'($urandom), 1'($urandom), a));
    if (plan_waiting && a != plan_seq) begin
      plan_seq++;
      plan_waiting = 1'b0;
      plan_len     = 0;
    end
  endfunction

  function automatic void plan_ticks(int unsigned n);
    repeat (n) word_plan.push_back(word_of(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom)));
  endfunction

  function automatic void plan_none();
    word_plan.push_back(word_of(OP_NONE, 8'($urandom), 1'($urandom), 8'($urandom)));
  endfunction

  // Words that an idle sender ignores: stray acks, ticks and the unused code.
  function automatic void plan_idle_noise();
    case ($urandom_range(2))
      0:       plan_ack(8'($urandom));
      1:       plan_ticks(1);
      default: plan_none();
    endcase
  endfunction

  // One frame from first byte to completion. Most frames are short, a few
  // run up to the full store. While the frame waits for its ack it may see
  // tick runs (some reaching the timeout), repeated acks that force a replay,
  // stray bytes that get rejected and random acks that may close it early.
  function automatic void plan_frame();
    int unsigned len;
    int unsigned run;
    len = ($urandom_range(19) == 0) ? $urandom_range(9, MAX_PAYLOAD) : $urandom_range(1, 8);
    for (int unsigned i = 1; i <= len; i++) begin
      if ($urandom_range(7) == 0) plan_idle_noise();
      plan_byte(8'($urandom), i == len);
    end
    for (int k = $urandom_range(3); k > 0 && plan_waiting; k--) begin
      case ($urandom_range(5))
        0, 1: begin
          if (plan_timeout <= 16) run = $urandom_range(1, 2 * plan_timeout + 1);
          else if (plan_timeout <= 300 && $urandom_range(3) == 0) run = plan_timeout;
          else run = $urandom_range(1, 3);
          plan_ticks(run);
        end
        2:       plan_ack(plan_seq);
        3:       plan_byte(8'($urandom), 1'($urandom));
        4:       plan_none();
        default: plan_ack(8'($urandom));
      endcase
    end
    if (plan_waiting) plan_ack(plan_seq + 8'($urandom_range(1, 255)));
    if ($urandom_range(3) == 0) plan_idle_noise();
  endfunction

  function automatic void plan_random(int unsigned n_words);
    int unsigned target;
    target = word_plan.size() + n_words;
    while (word_plan.size() < target) plan_frame();
  endfunction

  // Offers the planned words in order. Valid drops only when the sender
  // chooses to idle, and the payload changes only after acceptance.
  task automatic drive_plan();
    sawa_in_t w;
    while (word_plan.size() != 0) begin
      w = word_plan.pop_front();
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk_i); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted word has come out, then lets the pipeline
  // drain of words that cause no result.
  task automatic settle();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The timeout register is written only with the block idle, so the shadow
  // takes the new value at the edge where the write is accepted.
  task automatic write_timeout(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    sb.timeout   = value;
    plan_timeout = value;
  endtask

  task automatic set_pressure(int unsigned src_pct, int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    sb = new(RESET_TIMEOUT);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset timeout: ignored words while idle, a
    // three-byte frame with its checksum, a byte rejected while waiting, a
    // replay on a repeated ack, completion, and a one-byte frame whose short
    // tick run stays below the timeout before it completes.
    plan_ticks(1);
    plan_ack(8'hFF);
    word_plan.push_back(word_of(OP_NONE, 8'hFF, 1'b1, 8'hFF));
    plan_byte(8'h00, 1'b0);
    plan_byte(8'hFF, 1'b0);
    plan_byte(8'h5A, 1'b1);
    plan_byte(8'hFF, 1'b1);
    plan_ack(8'h00);
    plan_ticks(1);
    plan_none();
    plan_ack(8'h01);
    plan_byte(8'h3C, 1'b1);
    plan_ticks(2);
    plan_ack(8'hFF);
    drive_plan();

    // Shortest timeout: every tick while waiting replays the frame.
    settle();
    write_timeout(16'd1);
    plan_random(5);
    drive_plan();

    // Sender gaps only.
    settle();
    write_timeout(16'd3);
    set_pressure(46, 0);
    plan_random(5);
    drive_plan();

    // Longest timeout, so only repeated acks replay. The receiver stalls at
    // random and holds off for a long stretch at the start, which fills the
    // command queue and stops the input side.
    settle();
    write_timeout(16'hFFFF);
    set_pressure(0, 46);
    hold_requests++;
    plan_random(5);
    drive_plan();

    // Both sides idle. A full-size frame closed on its sixtieth byte gives
    // the longest replays, once on a repeated ack and once on timeout.
    settle();
    write_timeout(16'($urandom_range(2, 12)));
    set_pressure(30, 30);
    for (int unsigned i = 1; i <= MAX_PAYLOAD; i++) plan_byte(8'($urandom), i == MAX_PAYLOAD);
    plan_ack(plan_seq);
    plan_ticks(plan_timeout);
    plan_ack(plan_seq ^ 8'h80);
    drive_plan();

    // Overflow comes last: a frame that fills the store without a last byte
    // never closes, so every later byte is rejected, marked last or not.
    settle();
    write_timeout(16'($urandom_range(2, 12)));
    set_pressure(30, 30);
    for (int unsigned i = 0; i < MAX_PAYLOAD; i++) plan_byte(8'($urandom), 1'b0);
    plan_byte(8'($urandom), 1'b1);
    plan_byte(8'($urandom), 1'b0);
    plan_byte(8'($urandom), 1'b1);
    plan_ack(8'($urandom));
    plan_ticks(2);
    plan_none();
    drive_plan();

    settle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(WATCHDOG_NS);
    $display("timeout: run did not finish, %0d result words still expected",
             sb.expected_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
